@@ sv/srd_pkg.sv @@
`timescale 1ns / 1ps

package srd_pkg;

   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int FRACTION_BITS    = 16;
   localparam int SINE_ADDR_BITS   = $clog2(SINE_TABLE_DEPTH);
   localparam int TRIG_WIDTH       = FRACTION_BITS + 2;

   localparam int FREQ_WIDTH = 24;
   localparam int TIME_WIDTH = 32;
   localparam int MAG_WIDTH  = 41;

   localparam logic [1:0] AXIS_X       = 2'd0;
   localparam logic [1:0] AXIS_Y       = 2'd1;
   localparam logic [1:0] AXIS_Z       = 2'd2;
   localparam logic [1:0] AXIS_HEADING = 2'd3;

   // 2^64 / (2 pi), split in 32-bit halves
   localparam logic [31:0] INV_TWO_PI_LO = 32'h9391_054A;
   localparam logic [31:0] INV_TWO_PI_HI = 32'h28BE_60DB;
   localparam logic [31:0] QUARTER_TURN  = 32'h4000_0000;

   localparam logic [MAG_WIDTH-1:0] MAG_CAP = MAG_WIDTH'(64'd1 << 40);
   localparam logic signed [49:0]   Z_OFFSET = 50'sd98304;

   // output rounding shift after amplitude scaling (amplitude held in quarters)
   localparam int OUT_SHIFT = FRACTION_BITS + 2 - 16;
   localparam int OUT_SHR   = (OUT_SHIFT > 0) ? OUT_SHIFT : 0;
   localparam int OUT_SHL   = (OUT_SHIFT < 0) ? -OUT_SHIFT : 0;
   localparam logic [47:0] OUT_ROUND = (OUT_SHIFT > 0) ? (48'd1 << (OUT_SHR - 1)) : 48'd0;

   localparam longint unsigned PI_Q32 = 64'h3_243F_6A89;

   typedef logic signed [TRIG_WIDTH-1:0] trig_type;
   typedef logic [MAG_WIDTH-1:0] mag_type;
   typedef trig_type sine_table_type [SINE_TABLE_DEPTH];

   typedef struct packed {
      logic [1:0]            axis;
      logic                  wneg;
      logic [FREQ_WIDTH-1:0] wabs;
   } meta_type;

   typedef struct packed {
      logic [1:0]            axis;
      logic                  wneg;
      logic [FREQ_WIDTH-1:0] wabs;
      logic                  t0neg;
      logic                  t1neg;
      mag_type               m0;
      mag_type               m1;
      mag_type               ma;
      mag_type               mb;
      logic [40:0]           pa_hi;
      logic [47:0]           pa_lo;
      logic [40:0]           pb_hi;
      logic [47:0]           pb_lo;
   } deriv_type;

   // restoring long division, used only while the table is built
   function automatic longint unsigned const_div(longint unsigned num,
                                                 longint unsigned den);
      longint unsigned q;
      longint unsigned r;
      q = 0;
      r = 0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[62:0], num[i]};
         if (r >= den) begin
            r = r - den;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // Taylor series of sin over the first quadrant, Q30, folded by symmetry
   function automatic trig_type table_entry(longint k);
      longint d;
      longint rn_s;
      longint unsigned rn;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned v;
      longint sum;
      bit neg;
      int sh;
      d = SINE_TABLE_DEPTH;
      neg = 1'b0;
      if (4 * k < d) rn_s = 2 * k;
      else if (4 * k < 3 * d) rn_s = d - 2 * k;
      else rn_s = 2 * k - 2 * d;
      if (rn_s < 0) begin
         neg = 1'b1;
         rn_s = -rn_s;
      end
      rn = longint'(rn_s);
      x = (rn * PI_Q32 + 2 * longint'(d)) >> (SINE_ADDR_BITS + 2);
      x2 = (x * x) >> 30;
      sum = longint'(x);
      term = x;
      for (int n = 3; n <= 17; n += 2) begin
         term = const_div((term * x2) >> 30, longint'((n - 1) * n));
         if ((((n - 1) >> 1) & 1) != 0) sum = sum - longint'(term);
         else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      sh = 30 - FRACTION_BITS;
      v = (longint'(sum) + (64'd1 << (sh - 1))) >> sh;
      if (v > (64'd1 << FRACTION_BITS)) v = 64'd1 << FRACTION_BITS;
      return neg ? -trig_type'(v) : trig_type'(v);
   endfunction

   function automatic sine_table_type build_sine_table();
      sine_table_type t;
      for (int k = 0; k < SINE_TABLE_DEPTH; k++) t[k] = table_entry(longint'(k));
      return t;
   endfunction

   localparam sine_table_type SINE_TABLE = build_sine_table();

endpackage

@@ sv/sinusoid_reference_derivatives.sv @@
`timescale 1ns / 1ps

// Channel | Ports                                         | Direction
// req     | req_valid/req_stall, req_flying, req_elapsed_time | in
// rsp     | rsp_valid/rsp_stall, rsp_axis .. rsp_last_axis    | out
// csr     | csr_write, csr_index, csr_data                  | in (write only)
//
// A flying transaction is held by the axis sequencer, which issues its axes x, y, z,
// heading one at a time into a 14-stage pipeline whenever it advances. A grounded
// transaction is accepted and gives no result; a new one can be taken as heading issues.
// Reset clears frequencies, the sequencer and all valid bits.
// A rsp stall while rsp_valid is high freezes the whole pipeline; nothing is lost or repeated.
module sinusoid_reference_derivatives
   import srd_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_flying,
   input  logic [TIME_WIDTH-1:0]        req_elapsed_time,
   input  logic                         csr_write,
   input  logic [1:0]                   csr_index,
   input  logic [FREQ_WIDTH-1:0]        csr_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_axis,
   output logic signed [31:0]           rsp_position,
   output logic signed [31:0]           rsp_rate,
   output logic signed [31:0]           rsp_accel,
   output logic signed [31:0]           rsp_jerk,
   output logic                         rsp_last_axis
);

   // ---------------------------------------------------------------------
   // Helpers
   // ---------------------------------------------------------------------

   // finish one derivative step: round off 16 bits, cap the magnitude
   function automatic mag_type step_finish(logic [40:0] phi, logic [47:0] plo);
      logic [65:0] sum;
      logic [49:0] r;
      sum = (66'(phi) << 24) + 66'(plo) + 66'd32768;
      r = sum[65:16];
      return (r > 50'(MAG_CAP)) ? MAG_CAP : r[MAG_WIDTH-1:0];
   endfunction

   // amplitude (1.0 or 0.25), round to output scale, apply sign
   function automatic logic signed [49:0] term_value(mag_type m, logic amp_full,
                                                      logic neg);
      logic [47:0] scaled;
      logic [47:0] r;
      scaled = amp_full ? (48'(m) << 2) : 48'(m);
      r = ((scaled + OUT_ROUND) >> OUT_SHR) << OUT_SHL;
      return neg ? -$signed({2'b00, r}) : $signed({2'b00, r});
   endfunction

   function automatic logic signed [31:0] sat32(logic signed [49:0] v);
      if (v > 50'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -50'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // ---------------------------------------------------------------------
   // Configuration
   // ---------------------------------------------------------------------
   logic signed [FREQ_WIDTH-1:0] freq_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) freq_ff[i] <= '0;
      end else if (csr_write) begin
         freq_ff[csr_index] <= csr_data;
      end
   end

   // ---------------------------------------------------------------------
   // Axis sequencer: hold one transaction, issue x, y, z, heading
   // ---------------------------------------------------------------------
   logic                  adv;
   logic                  issue;
   logic                  req_accept;
   logic                  seq_busy_ff, seq_busy_in;
   logic [1:0]            seq_axis_ff, seq_axis_in;
   logic [TIME_WIDTH-1:0] seq_time_ff, seq_time_in;
   logic                  rsp_valid_ff;

   // the pipeline moves whenever the output slot is free or being taken
   assign adv        = !rsp_valid_ff || !rsp_stall;
   assign issue      = seq_busy_ff && adv;
   assign req_stall  = seq_busy_ff && !(issue && seq_axis_ff == AXIS_HEADING);
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      seq_busy_in = seq_busy_ff;
      seq_axis_in = seq_axis_ff;
      seq_time_in = seq_time_ff;
      if (issue) begin
         seq_axis_in = seq_axis_ff + 2'd1;
         if (seq_axis_ff == AXIS_HEADING) seq_busy_in = 1'b0;
      end
      // a grounded transaction is simply dropped
      if (req_accept && req_flying) begin
         seq_busy_in = 1'b1;
         seq_axis_in = AXIS_X;
         seq_time_in = req_elapsed_time;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_busy_ff <= 1'b0;
         seq_axis_ff <= AXIS_X;
      end else begin
         seq_busy_ff <= seq_busy_in;
         seq_axis_ff <= seq_axis_in;
      end
      seq_time_ff <= seq_time_in;
   end

   // ---------------------------------------------------------------------
   // Pipeline valid bits, stages 1..13 (stage 14 is the output register)
   // ---------------------------------------------------------------------
   logic [13:1] vld_ff;
   meta_type    meta_ff [6];
   meta_type    meta_in;
   logic signed [FREQ_WIDTH-1:0] wsel;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[12:1], issue};
         rsp_valid_ff <= vld_ff[13];
      end
   end

   assign wsel         = freq_ff[seq_axis_ff];
   assign meta_in.axis = seq_axis_ff;
   assign meta_in.wneg = wsel[FREQ_WIDTH-1];
   assign meta_in.wabs = wsel[FREQ_WIDTH-1] ? FREQ_WIDTH'(-wsel) : FREQ_WIDTH'(wsel);

   always_ff @(posedge clock) begin
      if (adv) begin
         meta_ff[0] <= meta_in;
         for (int i = 1; i < 6; i++) meta_ff[i] <= meta_ff[i-1];
      end
   end

   // ---------------------------------------------------------------------
   // Stages 1..4: phase = floor(|w t| / 2 pi) mod 2^32, negated for w < 0
   // ---------------------------------------------------------------------
   logic [55:0] s1_prod_ff;
   logic [63:0] s2_lo_ff;
   logic [55:0] s2_m1_ff;
   logic [63:0] s2_m2_ff;
   logic [31:0] s2_hi_ff;
   logic [33:0] s3_carry_in;
   logic [1:0]  s3_carry_ff;
   logic [31:0] s3_sum_ff;
   logic [31:0] s4_turn;
   logic [31:0] s4_phase_ff;

   assign s3_carry_in = 34'(s2_lo_ff[63:32]) + 34'(s2_m1_ff[31:0]) + 34'(s2_m2_ff[31:0]);
   assign s4_turn     = s3_sum_ff + 32'(s3_carry_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_prod_ff  <= 56'(meta_in.wabs) * 56'(seq_time_ff);
         s2_lo_ff    <= 64'(s1_prod_ff[31:0]) * 64'(INV_TWO_PI_LO);
         s2_m1_ff    <= 56'(s1_prod_ff[55:32]) * 56'(INV_TWO_PI_LO);
         s2_m2_ff    <= 64'(s1_prod_ff[31:0]) * 64'(INV_TWO_PI_HI);
         s2_hi_ff    <= 32'(s1_prod_ff[55:32]) * INV_TWO_PI_HI;
         s3_carry_ff <= s3_carry_in[33:32];
         s3_sum_ff   <= s2_hi_ff + 32'(s2_m1_ff[55:32]) + s2_m2_ff[63:32];
         s4_phase_ff <= meta_ff[2].wneg ? (32'd0 - s4_turn) : s4_turn;
      end
   end

   // ---------------------------------------------------------------------
   // Stages 5..6: table index, then registered sine ROM read (two ports)
   // ---------------------------------------------------------------------
   logic [31:0]               s5_phase_c;
   logic [47:0]               s5_prod_s;
   logic [47:0]               s5_prod_c;
   logic [SINE_ADDR_BITS-1:0] s5_idx_s_ff;
   logic [SINE_ADDR_BITS-1:0] s5_idx_c_ff;
   trig_type                  s6_sin_ff;
   trig_type                  s6_cos_ff;

   assign s5_phase_c = s4_phase_ff + QUARTER_TURN;
   assign s5_prod_s  = 48'(s4_phase_ff) * 48'(SINE_TABLE_DEPTH);
   assign s5_prod_c  = 48'(s5_phase_c) * 48'(SINE_TABLE_DEPTH);

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_idx_s_ff <= s5_prod_s[32 +: SINE_ADDR_BITS];
         s5_idx_c_ff <= s5_prod_c[32 +: SINE_ADDR_BITS];
         s6_sin_ff   <= SINE_TABLE[s5_idx_s_ff];
         s6_cos_ff   <= SINE_TABLE[s5_idx_c_ff];
      end
   end

   // ---------------------------------------------------------------------
   // Stages 7..13: derivative magnitudes. Chain B runs on the odd-order
   // trig value (three steps), chain A on the even one (two steps). Each
   // step multiplies in two partial products, then adds, rounds and caps.
   // ---------------------------------------------------------------------
   deriv_type dr_ff [7];
   deriv_type dr_in [7];
   trig_type  t0;
   trig_type  t1;
   logic      cos_first;

   // y and heading start from cosine, x and z from sine
   assign cos_first = (meta_ff[5].axis == AXIS_Y) || (meta_ff[5].axis == AXIS_HEADING);
   assign t0        = cos_first ? s6_cos_ff : s6_sin_ff;
   assign t1        = cos_first ? s6_sin_ff : s6_cos_ff;

   always_comb begin
      dr_in[0]       = dr_ff[0];
      dr_in[0].axis  = meta_ff[5].axis;
      dr_in[0].wneg  = meta_ff[5].wneg;
      dr_in[0].wabs  = meta_ff[5].wabs;
      dr_in[0].t0neg = t0[TRIG_WIDTH-1];
      dr_in[0].t1neg = t1[TRIG_WIDTH-1];
      dr_in[0].m0    = MAG_WIDTH'(t0[TRIG_WIDTH-1] ? TRIG_WIDTH'(-t0) : TRIG_WIDTH'(t0));
      dr_in[0].ma    = MAG_WIDTH'(t0[TRIG_WIDTH-1] ? TRIG_WIDTH'(-t0) : TRIG_WIDTH'(t0));
      dr_in[0].mb    = MAG_WIDTH'(t1[TRIG_WIDTH-1] ? TRIG_WIDTH'(-t1) : TRIG_WIDTH'(t1));

      // first step, chain B
      dr_in[1]       = dr_ff[0];
      dr_in[1].pb_hi = 41'(dr_ff[0].mb[40:24]) * 41'(dr_ff[0].wabs);
      dr_in[1].pb_lo = 48'(dr_ff[0].mb[23:0]) * 48'(dr_ff[0].wabs);

      dr_in[2]       = dr_ff[1];
      dr_in[2].mb    = step_finish(dr_ff[1].pb_hi, dr_ff[1].pb_lo);
      dr_in[2].m1    = step_finish(dr_ff[1].pb_hi, dr_ff[1].pb_lo);

      // second step, both chains
      dr_in[3]       = dr_ff[2];
      dr_in[3].pa_hi = 41'(dr_ff[2].ma[40:24]) * 41'(dr_ff[2].wabs);
      dr_in[3].pa_lo = 48'(dr_ff[2].ma[23:0]) * 48'(dr_ff[2].wabs);
      dr_in[3].pb_hi = 41'(dr_ff[2].mb[40:24]) * 41'(dr_ff[2].wabs);
      dr_in[3].pb_lo = 48'(dr_ff[2].mb[23:0]) * 48'(dr_ff[2].wabs);

      dr_in[4]       = dr_ff[3];
      dr_in[4].ma    = step_finish(dr_ff[3].pa_hi, dr_ff[3].pa_lo);
      dr_in[4].mb    = step_finish(dr_ff[3].pb_hi, dr_ff[3].pb_lo);

      // third step, both chains: ma becomes order 2, mb order 3
      dr_in[5]       = dr_ff[4];
      dr_in[5].pa_hi = 41'(dr_ff[4].ma[40:24]) * 41'(dr_ff[4].wabs);
      dr_in[5].pa_lo = 48'(dr_ff[4].ma[23:0]) * 48'(dr_ff[4].wabs);
      dr_in[5].pb_hi = 41'(dr_ff[4].mb[40:24]) * 41'(dr_ff[4].wabs);
      dr_in[5].pb_lo = 48'(dr_ff[4].mb[23:0]) * 48'(dr_ff[4].wabs);

      dr_in[6]       = dr_ff[5];
      dr_in[6].ma    = step_finish(dr_ff[5].pa_hi, dr_ff[5].pa_lo);
      dr_in[6].mb    = step_finish(dr_ff[5].pb_hi, dr_ff[5].pb_lo);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 7; i++) dr_ff[i] <= dr_in[i];
      end
   end

   // ---------------------------------------------------------------------
   // Stage 14: signs, amplitude, z offset, saturation -> output register
   // ---------------------------------------------------------------------
   deriv_type          fin;
   logic               amp_full;
   logic               flip1, flip2, flip3;
   logic signed [49:0] v0, v1, v2, v3;
   logic signed [49:0] pos_val;
   logic [1:0]         rsp_axis_ff;
   logic signed [31:0] rsp_position_ff, rsp_rate_ff, rsp_accel_ff, rsp_jerk_ff;
   logic               rsp_last_axis_ff;

   assign fin = dr_ff[6];
   assign amp_full = (fin.axis != AXIS_HEADING);

   // sign flips that the waveform itself adds per derivative order
   always_comb begin
      case (fin.axis)
         AXIS_X: begin
            flip1 = 1'b0; flip2 = 1'b1; flip3 = 1'b1;
         end
         AXIS_Y: begin
            flip1 = 1'b1; flip2 = 1'b1; flip3 = 1'b0;
         end
         AXIS_Z: begin
            flip1 = 1'b1; flip2 = 1'b0; flip3 = 1'b0;
         end
         AXIS_HEADING: begin
            flip1 = 1'b1; flip2 = 1'b0; flip3 = 1'b0;
         end
         default: begin
            flip1 = 1'b0; flip2 = 1'b0; flip3 = 1'b0;
         end
      endcase
   end

   assign v0 = term_value(fin.m0, amp_full, fin.t0neg);
   assign v1 = term_value(fin.m1, amp_full, fin.t1neg ^ flip1 ^ fin.wneg);
   assign v2 = term_value(fin.ma, amp_full, fin.t0neg ^ flip2);
   assign v3 = term_value(fin.mb, amp_full, fin.t1neg ^ flip3 ^ fin.wneg);
   // z hovers at 1.5 and dips with the sine
   assign pos_val = (fin.axis == AXIS_Z) ? (Z_OFFSET - v0) : v0;

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_axis_ff      <= fin.axis;
         rsp_position_ff  <= sat32(pos_val);
         rsp_rate_ff      <= sat32(v1);
         rsp_accel_ff     <= (fin.axis == AXIS_HEADING) ? 32'sd0 : sat32(v2);
         rsp_jerk_ff      <= (fin.axis == AXIS_HEADING) ? 32'sd0 : sat32(v3);
         rsp_last_axis_ff <= (fin.axis == AXIS_HEADING);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_axis      = rsp_axis_ff;
   assign rsp_position  = rsp_position_ff;
   assign rsp_rate      = rsp_rate_ff;
   assign rsp_accel     = rsp_accel_ff;
   assign rsp_jerk      = rsp_jerk_ff;
   assign rsp_last_axis = rsp_last_axis_ff;

endmodule
